[rtl/core/bmpq_pkg.sv]
package bmpq_pkg;

  localparam int DEPTH_DEFAULT = 8;
  localparam int DATA_W        = 32;
  localparam int OCC_W         = 4;
  localparam int STATUS_W      = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] priority_q;
    logic signed [DATA_W-1:0] value_q;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic occupied;
  } cell_ctl_t;

  // a ranks above b: higher priority, or equal priority and larger value
  function automatic logic entry_gt(entry_t a, entry_t b);
    logic pri_gt;
    logic pri_eq;
    logic val_gt;
    pri_gt = a.priority_q > b.priority_q;
    pri_eq = a.priority_q == b.priority_q;
    val_gt = a.value_q > b.value_q;
    return pri_gt || (pri_eq && val_gt);
  endfunction

endpackage

[rtl/core/bmpq_cell.sv]
module bmpq_cell (
  input  logic              clk,
  input  bmpq_pkg::cell_ctl_t ctl,
  input  bmpq_pkg::entry_t  new_entry,
  input  bmpq_pkg::entry_t  up_entry,
  input  logic              up_beat,
  input  bmpq_pkg::entry_t  dn_entry,
  output bmpq_pkg::entry_t  entry,
  output logic              beat
);
  import bmpq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // new item outranks this cell, an empty cell loses to anything
  assign beat  = ctl.occupied ? entry_gt(new_entry, entry_r) : 1'b1;
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.push) begin
      if (up_beat) begin
        entry_nxt = up_entry;
      end else if (beat) begin
        entry_nxt = new_entry;
      end
    end else if (ctl.pop) begin
      entry_nxt = dn_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

[rtl/core/bounded_max_priority_queue.sv]
// Bounded max priority queue of (value, priority) pairs.
// Input channel (in_valid/in_ready): in_cmd selects push or pop; a push
// carries in_item_value and in_item_priority, which a pop ignores.
// Result channel (out_valid/out_ready): one item per input item with
// out_status (ok, full, empty), the popped pair on a good pop (else zero)
// and out_occupancy, the count held after the operation.
// Entries sit in a row of cells kept sorted, highest first: a push inserts
// with every cell comparing against the new pair, a pop takes the head and
// shifts the row up by one.
// The result is registered and appears in the cycle after the item is accepted.
// Throughput: one item per cycle while out_ready is high; the single
// output register holds a result until taken, and in_ready is low only
// while that register is full and out_ready is low.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; cell contents are not cleared, as the count marks held cells.
module bounded_max_priority_queue #(
  parameter int DEPTH = bmpq_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic signed [bmpq_pkg::DATA_W-1:0]  in_item_value,
  input  logic signed [bmpq_pkg::DATA_W-1:0]  in_item_priority,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [bmpq_pkg::STATUS_W-1:0] out_status,
  output logic signed [bmpq_pkg::DATA_W-1:0]  out_popped_value,
  output logic signed [bmpq_pkg::DATA_W-1:0]  out_popped_priority,
  output logic        [bmpq_pkg::OCC_W-1:0]   out_occupancy
);
  import bmpq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  status_t          status_r;
  status_t          status_nxt;
  entry_t           res_r;
  entry_t           res_nxt;
  logic [CNT_W-1:0] occ_r;

  logic   accept;
  logic   is_full;
  logic   is_empty;
  logic   do_push;
  logic   do_pop;
  entry_t new_entry;
  entry_t cell_q [DEPTH];
  logic   beat [DEPTH];

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign is_full   = count_r == CNT_W'(DEPTH);
  assign is_empty  = count_r == '0;
  assign do_push   = accept && (in_cmd == CMD_PUSH) && !is_full;
  assign do_pop    = accept && (in_cmd == CMD_POP) && !is_empty;
  assign new_entry = '{priority_q: in_item_priority, value_q: in_item_value};

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctl_t ctl;
      entry_t    up_entry;
      logic      up_beat;
      entry_t    dn_entry;

      assign ctl.push     = do_push;
      assign ctl.pop      = do_pop;
      assign ctl.occupied = CNT_W'(i) < count_r;

      if (i == 0) begin : g_head
        assign up_entry = new_entry;
        assign up_beat  = 1'b0;
      end else begin : g_body
        assign up_entry = cell_q[i-1];
        assign up_beat  = beat[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign dn_entry = cell_q[i];
      end else begin : g_mid
        assign dn_entry = cell_q[i+1];
      end

      bmpq_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .new_entry (new_entry),
        .up_entry  (up_entry),
        .up_beat   (up_beat),
        .dn_entry  (dn_entry),
        .entry     (cell_q[i]),
        .beat      (beat[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    res_nxt       = res_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      status_nxt    = ST_OK;
      res_nxt       = '0;
      if (in_cmd == CMD_PUSH) begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end else begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          res_nxt   = cell_q[0];
          count_nxt = count_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    res_r    <= res_nxt;
    if (accept) begin
      occ_r <= count_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_popped_value    = res_r.value_q;
  assign out_popped_priority = res_r.priority_q;
  assign out_occupancy       = OCC_W'(occ_r);

endmodule
